/* rtl/balag_pkg.sv */
// shared widths, constants and interface types of the band level auto gain block
package balag_pkg;

   // field and state widths
   localparam int BAND_W   = 16;
   localparam int FLOOR_W  = 12;
   localparam int GAIN_W   = 16;
   localparam int LEVEL_W  = 16;
   localparam int STATE_W  = 20;
   localparam int AVG_W    = 17;
   localparam int TOTAL_W  = 18;

   // shared divider geometry: radix-16, one digit per cycle
   localparam int DIVD_W   = 32;
   localparam int DIVS_W   = 20;
   localparam int DIGIT_W  = 4;
   localparam int STEP_W   = 4;

   // stream payload widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_BITS   = 3 * BAND_W + 3 * AVG_W + TOTAL_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_FLOOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN        = 1'd1;

   // reset values
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = 12'd41;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd6144;
   localparam logic [STATE_W-1:0] STATE_RESET = 20'd81920;
   localparam logic [BAND_W-1:0]  NORM_MAX    = 16'hFFFF;

   // divide request from the sequencer
   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;   // left aligned, top steps digits used
      logic [DIVS_W-1:0] divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   // divide result back to the sequencer
   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

   // sequencer status toward the stream side
   typedef struct packed {
      logic idle;
      logic fin_valid;
   } core_stat_type;

   // one result, first member in the highest bits
   typedef struct packed {
      logic [TOTAL_W-1:0] total_level;
      logic [AVG_W-1:0]   treble_avg;
      logic [AVG_W-1:0]   mid_avg;
      logic [AVG_W-1:0]   bass_avg;
      logic [BAND_W-1:0]  treble_norm;
      logic [BAND_W-1:0]  mid_norm;
      logic [BAND_W-1:0]  bass_norm;
   } result_type;

endpackage

/* rtl/balag_div.sv */
// shared iterative unsigned divider, one radix-16 digit per cycle
module balag_div (
   input  logic                 clock,
   input  logic                 reset,
   input  balag_pkg::div_req_type req,
   output balag_pkg::div_rsp_type rsp
);
   import balag_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [DIVD_W-1:0]   quo_ff, quo_in;
   logic [DIVS_W-1:0]   rem_ff, rem_in;
   logic [DIVS_W-1:0]   dvs_ff, dvs_in;
   logic [DIVD_W-1:0]   quo_step;
   logic [DIVS_W-1:0]   rem_step;

   // four restoring steps per cycle
   always_comb begin
      logic [DIVS_W:0]   trial;
      logic [DIVD_W-1:0] q;
      logic [DIVS_W-1:0] r;
      q = quo_ff;
      r = rem_ff;
      for (int k = 0; k < DIGIT_W; k++) begin
         trial = {r, q[DIVD_W-1]};
         q = {q[DIVD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial = trial - {1'b0, dvs_ff};
            q[0] = 1'b1;
         end
         r = trial[DIVS_W-1:0];
      end
      quo_step = q;
      rem_step = r;
   end

   // load on start, iterate while busy
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* rtl/balag_core.sv */
// sequencer, multiply-add front end and gain state around the shared divider
module balag_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [balag_pkg::BAND_W-1:0]   bass_power,
   input  logic [balag_pkg::BAND_W-1:0]   mid_power,
   input  logic [balag_pkg::BAND_W-1:0]   treble_power,
   input  logic [balag_pkg::FLOOR_W-1:0]  level_floor,
   input  logic [balag_pkg::GAIN_W-1:0]   gain,
   input  logic                           out_free,
   output balag_pkg::core_stat_type       stat,
   output balag_pkg::result_type          result,
   output balag_pkg::div_req_type         div_req,
   input  balag_pkg::div_rsp_type         div_rsp
);
   import balag_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // divide operations in order
   localparam logic [2:0] OP_LVL   = 3'd0;
   localparam logic [2:0] OP_VOL   = 3'd1;
   localparam logic [2:0] OP_NORM0 = 3'd2;
   localparam logic [2:0] OP_NORM1 = 3'd3;
   localparam logic [2:0] OP_NORM2 = 3'd4;
   localparam logic [2:0] OP_AVG0  = 3'd5;
   localparam logic [2:0] OP_AVG1  = 3'd6;
   localparam logic [2:0] OP_AVG2  = 3'd7;

   // digits per operation and matching left alignment
   localparam int STEPS_LVL  = 5;
   localparam int STEPS_VOL  = 6;
   localparam int STEPS_NORM = 8;
   localparam int STEPS_AVG  = 5;
   localparam int ALIGN_LVL  = DIVD_W - DIGIT_W * STEPS_LVL;
   localparam int ALIGN_VOL  = DIVD_W - DIGIT_W * STEPS_VOL;
   localparam int ALIGN_NORM = DIVD_W - DIGIT_W * STEPS_NORM;
   localparam int ALIGN_AVG  = DIVD_W - DIGIT_W * STEPS_AVG;
   localparam int PROD_W     = STATE_W + GAIN_W;

   // constant multipliers and divisors
   localparam logic [GAIN_W-1:0] MUL_ONE = 16'd1;
   localparam logic [GAIN_W-1:0] MUL_VOL = 16'd29;
   localparam logic [GAIN_W-1:0] MUL_AVG = 16'd5;
   localparam logic [DIVS_W-1:0] DIV_LVL = 20'd3;
   localparam logic [DIVS_W-1:0] DIV_VOL = 20'd30;
   localparam logic [DIVS_W-1:0] DIV_AVG = 20'd6;

   logic [1:0]          state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic [BAND_W-1:0]   band_ff [3];
   logic [BAND_W-1:0]   norm_ff [3];
   logic [STATE_W-1:0]  avg_ff  [3];
   logic [STATE_W-1:0]  vol_ff;
   logic [LEVEL_W-1:0]  level_ff;

   logic [1:0]          idx;
   logic [TOTAL_W-1:0]  band_sum;
   logic [STATE_W-1:0]  vol_div;
   logic [STATE_W-1:0]  mul_a;
   logic [GAIN_W-1:0]   mul_b;
   logic [STATE_W-1:0]  add_val;
   logic [PROD_W-1:0]   prod;
   logic [DIVD_W-1:0]   macc;
   logic [DIVD_W-1:0]   dividend;
   logic [DIVS_W-1:0]   divisor;
   logic [STEP_W-1:0]   steps;
   logic [LEVEL_W-1:0]  q_level;
   logic [LEVEL_W-1:0]  level_in;
   logic [BAND_W-1:0]   q_sat;

   // band slot of the current operation
   always_comb begin
      case (op_ff)
         OP_NORM1, OP_AVG1: idx = 2'd1;
         OP_NORM2, OP_AVG2: idx = 2'd2;
         default:           idx = 2'd0;
      endcase
   end

   assign band_sum = TOTAL_W'(band_ff[0]) + TOTAL_W'(band_ff[1]) + TOTAL_W'(band_ff[2]);
   assign vol_div  = (vol_ff == '0) ? STATE_W'(1) : vol_ff;

   // operand select for the shared multiply-add
   always_comb begin
      case (op_ff)
         OP_LVL: begin
            mul_a   = STATE_W'(band_sum);
            mul_b   = MUL_ONE;
            add_val = '0;
            divisor = DIV_LVL;
            steps   = STEP_W'(STEPS_LVL);
         end
         OP_VOL: begin
            mul_a   = vol_ff;
            mul_b   = MUL_VOL;
            add_val = STATE_W'(level_ff);
            divisor = DIV_VOL;
            steps   = STEP_W'(STEPS_VOL);
         end
         OP_NORM0, OP_NORM1, OP_NORM2: begin
            mul_a   = STATE_W'(band_ff[idx]);
            mul_b   = gain;
            add_val = '0;
            divisor = vol_div;
            steps   = STEP_W'(STEPS_NORM);
         end
         default: begin
            mul_a   = avg_ff[idx];
            mul_b   = MUL_AVG;
            add_val = STATE_W'(norm_ff[idx]);
            divisor = DIV_AVG;
            steps   = STEP_W'(STEPS_AVG);
         end
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign macc = prod[DIVD_W-1:0] + DIVD_W'(add_val);

   // left align the dividend to the digits used
   always_comb begin
      case (op_ff)
         OP_LVL:                       dividend = macc << ALIGN_LVL;
         OP_VOL:                       dividend = macc << ALIGN_VOL;
         OP_NORM0, OP_NORM1, OP_NORM2: dividend = macc << ALIGN_NORM;
         default:                      dividend = macc << ALIGN_AVG;
      endcase
   end

   assign div_req.start    = (state_ff == ST_ISSUE);
   assign div_req.dividend = dividend;
   assign div_req.divisor  = divisor;
   assign div_req.steps    = steps;

   // quotient post-processing
   assign q_level  = div_rsp.quotient[LEVEL_W-1:0];
   assign level_in = (q_level < LEVEL_W'(level_floor)) ? LEVEL_W'(level_floor) : q_level;
   assign q_sat    = (|div_rsp.quotient[DIVD_W-1:BAND_W]) ? NORM_MAX
                                                         : div_rsp.quotient[BAND_W-1:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ISSUE;
               op_in    = OP_LVL;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_rsp.done) begin
               if (op_ff == OP_AVG2) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_ISSUE;
                  op_in    = op_ff + 3'd1;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state and gain state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_LVL;
         vol_ff   <= STATE_RESET;
         avg_ff[0] <= STATE_RESET;
         avg_ff[1] <= STATE_RESET;
         avg_ff[2] <= STATE_RESET;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         if (state_ff == ST_WAIT && div_rsp.done) begin
            if (op_ff == OP_VOL) begin
               vol_ff <= div_rsp.quotient[STATE_W-1:0];
            end
            if (op_ff == OP_AVG0 || op_ff == OP_AVG1 || op_ff == OP_AVG2) begin
               avg_ff[idx] <= div_rsp.quotient[STATE_W-1:0];
            end
         end
      end
   end

   // per-transaction working registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         band_ff[0] <= bass_power;
         band_ff[1] <= mid_power;
         band_ff[2] <= treble_power;
      end
      if (state_ff == ST_WAIT && div_rsp.done) begin
         if (op_ff == OP_LVL) begin
            level_ff <= level_in;
         end
         if (op_ff == OP_NORM0 || op_ff == OP_NORM1 || op_ff == OP_NORM2) begin
            norm_ff[idx] <= q_sat;
         end
      end
   end

   // status and result
   assign stat.idle      = (state_ff == ST_IDLE);
   assign stat.fin_valid = (state_ff == ST_FINISH);

   assign result.bass_norm   = norm_ff[0];
   assign result.mid_norm    = norm_ff[1];
   assign result.treble_norm = norm_ff[2];
   assign result.bass_avg    = avg_ff[0][AVG_W-1:0];
   assign result.mid_avg     = avg_ff[1][AVG_W-1:0];
   assign result.treble_avg  = avg_ff[2][AVG_W-1:0];
   assign result.total_level = TOTAL_W'(norm_ff[0]) + TOTAL_W'(norm_ff[1])
                             + TOTAL_W'(norm_ff[2]);

endmodule

/* rtl/band_level_auto_gain.sv */
// band level auto gain: top level with stream ports, settings registers and output register
// sequencing: each accepted req transaction takes eight passes through the shared
//   radix-16 divider, each pass with an issue and a capture state, and then the finish
//   state of the sequencer; req_tready stays low until the sequencer is back in idle,
//   and the finish state waits while the output register is full and rsp_tready is low
// reset: synchronous, active high; volume and band averages return to 81920,
//   level_floor to 41, gain to 6144, both channels empty
module band_level_auto_gain (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bass_power, mid_power, treble_power
   input  logic [balag_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // bass_norm, mid_norm, treble_norm, bass_avg, mid_avg, treble_avg, total_level, zero pad
   output logic [balag_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_wen,
   input  logic [balag_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [balag_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import balag_pkg::*;

   logic [FLOOR_W-1:0]    floor_ff;
   logic [GAIN_W-1:0]     gain_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_data_ff;
   logic                  out_free;
   logic                  start;
   core_stat_type         stat;
   result_type            result;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_RESET;
         gain_ff  <= GAIN_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_LEVEL_FLOOR: floor_ff <= csr_wdata[FLOOR_W-1:0];
            CSR_GAIN:        gain_ff  <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // input handshake
   assign req_tready = stat.idle;
   assign start      = req_tvalid && stat.idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   balag_core u_core (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .bass_power   (req_tdata[15:0]),
      .mid_power    (req_tdata[31:16]),
      .treble_power (req_tdata[47:32]),
      .level_floor  (floor_ff),
      .gain         (gain_ff),
      .out_free     (out_free),
      .stat         (stat),
      .result       (result),
      .div_req      (div_req),
      .div_rsp      (div_rsp)
   );

   balag_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.fin_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (stat.fin_valid && out_free) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

endmodule

/* test/band_level_auto_gain_tb.sv */
// self-checking stream testbench for the band level auto gain block
module band_level_auto_gain_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import balag_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 100;
   localparam int SILENT_ITEMS = 280;
   localparam int DIR_ROWS     = 28;

   typedef enum logic [1:0] {ROW_ITEM, ROW_FLOOR, ROW_GAIN} row_kind_type;

   // one directed row: a band triple, or a register write with its value in a
   typedef struct packed {
      row_kind_type      kind;
      logic [BAND_W-1:0] a;
      logic [BAND_W-1:0] b;
      logic [BAND_W-1:0] c;
      logic              typed;
   } stim_row_type;

   // silence right after reset: volume 79190, every average 68266, nothing scaled
   localparam result_type AFTER_RESET_SILENT = '{
      total_level: 18'd0,
      treble_avg:  17'd68266,
      mid_avg:     17'd68266,
      bass_avg:    17'd68266,
      treble_norm: 16'd0,
      mid_norm:    16'd0,
      bass_norm:   16'd0
   };

   localparam stim_row_type DIR_TABLE [DIR_ROWS] = '{
      '{ROW_ITEM,  16'h0000, 16'h0000, 16'h0000, 1'b1},
      '{ROW_ITEM,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
      '{ROW_ITEM,  16'hFFFF, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'h0000, 16'hFFFF, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'h0000, 16'h0000, 16'hFFFF, 1'b0},
      '{ROW_ITEM,  16'hAAAA, 16'h5555, 16'hAAAA, 1'b0},
      '{ROW_ITEM,  16'h5555, 16'hAAAA, 16'h5555, 1'b0},
      '{ROW_ITEM,  16'h0001, 16'h0002, 16'h0003, 1'b0},
      '{ROW_GAIN,  16'hFFFF, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'hFFFF, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'h0001, 16'h0000, 16'h0000, 1'b0},
      '{ROW_FLOOR, 16'h0FFF, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'h0FFF, 16'h1000, 16'h0000, 1'b0},
      '{ROW_GAIN,  16'h0001, 16'h0000, 16'h0000, 1'b0},
      '{ROW_FLOOR, 16'h0001, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
      '{ROW_ITEM,  16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{ROW_GAIN,  16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'h1234, 16'hFFFF, 16'h8000, 1'b0},
      '{ROW_ITEM,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
      '{ROW_FLOOR, 16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{ROW_GAIN,  16'h1800, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'h0000, 16'h0000, 16'hFFFF, 1'b0},
      '{ROW_FLOOR, 16'h0029, 16'h0000, 16'h0000, 1'b0},
      '{ROW_ITEM,  16'h8000, 16'h8000, 16'h8000, 1'b0},
      '{ROW_ITEM,  16'h7FFF, 16'h0000, 16'h0001, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the settings and the smoothing state
   logic [FLOOR_W-1:0] floor_reg = FLOOR_RESET;
   logic [GAIN_W-1:0]  gain_reg = GAIN_RESET;
   logic [STATE_W-1:0] volume_est = STATE_RESET;
   logic [STATE_W-1:0] band_avg_est [3] = '{STATE_RESET, STATE_RESET, STATE_RESET};

   result_type pending_levels [$];
   int         fail_count = 0;
   int         cycle_count = 0;
   int         req_calm = 0;
   int         rsp_calm = 0;

   band_level_auto_gain dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // mean level, volume update, scaling and per-band averaging for one frame
   function automatic result_type next_levels(input logic [BAND_W-1:0] bass,
                                              input logic [BAND_W-1:0] mid,
                                              input logic [BAND_W-1:0] treble);
      longint unsigned band [3];
      longint unsigned level, divisor, quot, total;
      result_type      res;
      band[0] = bass;
      band[1] = mid;
      band[2] = treble;
      total = 0;
      level = (band[0] + band[1] + band[2]) / 3;
      if (level < floor_reg)
         level = floor_reg;
      volume_est = STATE_W'((longint'(volume_est) * 29 + level) / 30);
      divisor = (volume_est == '0) ? 1 : volume_est;
      for (int i = 0; i < 3; i++) begin
         quot = (band[i] * gain_reg) / divisor;
         if (quot > NORM_MAX)
            quot = NORM_MAX;
         band[i] = quot;
         band_avg_est[i] = STATE_W'((longint'(band_avg_est[i]) * 5 + quot) / 6);
         total += quot;
      end
      res.bass_norm   = BAND_W'(band[0]);
      res.mid_norm    = BAND_W'(band[1]);
      res.treble_norm = BAND_W'(band[2]);
      res.bass_avg    = AVG_W'(band_avg_est[0]);
      res.mid_avg     = AVG_W'(band_avg_est[1]);
      res.treble_avg  = AVG_W'(band_avg_est[2]);
      res.total_level = TOTAL_W'(total);
      return res;
   endfunction

   // idle cycles before the next transaction, with stretches of none
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // band value biased toward the edges
   function automatic logic [BAND_W-1:0] rand_band();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return BAND_W'($urandom_range(0, 255));
         default: return BAND_W'($urandom);
      endcase
   endfunction

   // offer one frame, predict its result once accepted
   task automatic send_frame(input logic [BAND_W-1:0] bass, input logic [BAND_W-1:0] mid,
                             input logic [BAND_W-1:0] treble, input logic typed);
      int         gap;
      result_type want;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {treble, mid, bass};
      do @(posedge clock); while (!req_tready);
      want = next_levels(bass, mid, treble);
      pending_levels.push_back(typed ? AFTER_RESET_SILENT : want);
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_levels.size() != 0)
         @(posedge clock);
   endtask

   // register write, only while idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_wen <= 1'b0;
      if (idx == CSR_LEVEL_FLOOR)
         floor_reg = val[FLOOR_W-1:0];
      else if (idx == CSR_GAIN)
         gain_reg = val[GAIN_W-1:0];
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // result side: random stalls and one long hold-off
   initial begin : rsp_side
      int gap;
      int taken;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_wait(rsp_calm);
         if (gap > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken == HOLD_AT) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
      end
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[RSP_BITS-1:0]);
         check_field("pad", 0, rsp_tdata[RSP_DATA_W-1:RSP_BITS]);
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_levels.pop_front();
            check_field("bass_norm", want.bass_norm, got.bass_norm);
            check_field("mid_norm", want.mid_norm, got.mid_norm);
            check_field("treble_norm", want.treble_norm, got.treble_norm);
            check_field("bass_avg", want.bass_avg, got.bass_avg);
            check_field("mid_avg", want.mid_avg, got.mid_avg);
            check_field("treble_avg", want.treble_avg, got.treble_avg);
            check_field("total_level", want.total_level, got.total_level);
         end
      end
   end

   // stimulus sequence
   initial begin : req_side
      logic [FLOOR_W-1:0] floor_pick;
      logic [GAIN_W-1:0]  gain_pick;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         case (DIR_TABLE[r].kind)
            ROW_ITEM: begin
               send_frame(DIR_TABLE[r].a, DIR_TABLE[r].b, DIR_TABLE[r].c, DIR_TABLE[r].typed);
            end
            ROW_FLOOR: begin
               drain();
               write_csr(CSR_LEVEL_FLOOR, DIR_TABLE[r].a);
            end
            default: begin
               drain();
               write_csr(CSR_GAIN, DIR_TABLE[r].a);
            end
         endcase
      end

      // random phases, each with its own settings
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 4))
            0: floor_pick = 1;
            1: floor_pick = '1;
            2: floor_pick = FLOOR_RESET;
            3: floor_pick = '0;
            default: floor_pick = FLOOR_W'($urandom_range(1, 4095));
         endcase
         case ($urandom_range(0, 5))
            0: gain_pick = 1;
            1: gain_pick = '1;
            2: gain_pick = GAIN_RESET;
            3: gain_pick = '0;
            default: gain_pick = GAIN_W'($urandom_range(1, 65535));
         endcase
         drain();
         write_csr(CSR_LEVEL_FLOOR, CSR_DATA_W'(floor_pick));
         write_csr(CSR_GAIN, gain_pick);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_frame(rand_band(), rand_band(), rand_band(), 1'b0);
      end

      // zero floor and long silence: volume decays to zero, then small bands saturate
      drain();
      write_csr(CSR_LEVEL_FLOOR, '0);
      write_csr(CSR_GAIN, GAIN_W'($urandom_range(1, 65535)));
      for (int n = 0; n < SILENT_ITEMS; n++)
         send_frame('0, '0, '0, 1'b0);
      for (int n = 0; n < 30; n++)
         send_frame(BAND_W'($urandom_range(0, 3)), BAND_W'($urandom_range(0, 3)),
                    rand_band(), 1'b0);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_levels.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
